[design/slws_pkg.sv]
// shared types, constants and microcode for the sound level window statistics block
package slws_pkg;

  localparam int WINDOW_DEPTH = 100;
  localparam int RAW_W        = 10;
  localparam int LEVEL_W      = 7;
  localparam int THR_W        = 8;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = THR_W;
  localparam int LEVEL_MAX    = 100;

  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = $clog2(WINDOW_DEPTH * LEVEL_MAX + 1);
  localparam int ITER_W = $clog2(SUM_W + 1);

  // level mapping: 30 + floor(70 * raw / 1023)
  localparam int LEVEL_BASE = 30;
  localparam int LEVEL_SPAN = 70;
  localparam int RAW_FULL   = 1023;
  localparam int PROD_W     = RAW_W + 7;
  localparam int QUO_W      = PROD_W - RAW_W;

  localparam int STEP_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALERT_MODE  = 2'd0,
    CFG_CUSTOM_WARN = 2'd1,
    CFG_CUSTOM_ALRT = 2'd2,
    CFG_CUSTOM_DNGR = 2'd3
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFFICE = 2'd0,
    MODE_HOME   = 2'd1,
    MODE_SLEEP  = 2'd2,
    MODE_CUSTOM = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    GRADE_OK     = 2'd0,
    GRADE_WARN   = 2'd1,
    GRADE_ALERT  = 2'd2,
    GRADE_DANGER = 2'd3
  } grade_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [THR_W-1:0]  warn;
    logic [THR_W-1:0]  alrt;
    logic [THR_W-1:0]  danger;
  } cfg_t;

  typedef struct packed {
    logic [THR_W-1:0] warn;
    logic [THR_W-1:0] alrt;
    logic [THR_W-1:0] danger;
  } thr_t;

  typedef enum logic [STEP_W-1:0] {
    STEP_WAIT     = 3'd0,
    STEP_SCAN     = 3'd1,
    STEP_DRAIN    = 3'd2,
    STEP_DIV      = 3'd3,
    STEP_DIV_WAIT = 3'd4,
    STEP_EMIT     = 3'd5
  } step_e;

  typedef enum logic [2:0] {
    COND_NONE      = 3'd0,
    COND_NO_INPUT  = 3'd1,
    COND_SCAN_MORE = 3'd2,
    COND_DIV_BUSY  = 3'd3,
    COND_OUT_FULL  = 3'd4
  } cond_e;

  // one control word of the microprogram
  typedef struct packed {
    logic  in_rdy;
    logic  rd;
    logic  div_go;
    logic  out_ld;
    cond_e cond;
    step_e tgt;
    logic  last;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic scan_more;
    logic div_busy;
    logic out_full;
  } status_t;

  function automatic ctl_t ucode(step_e s);
    ctl_t w;
    w = '0;
    case (s)
      STEP_WAIT: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.tgt    = STEP_WAIT;
      end
      STEP_SCAN: begin
        w.rd   = 1'b1;
        w.cond = COND_SCAN_MORE;
        w.tgt  = STEP_SCAN;
      end
      STEP_DRAIN: begin
        w.cond = COND_NONE;
        w.tgt  = STEP_WAIT;
      end
      STEP_DIV: begin
        w.div_go = 1'b1;
        w.cond   = COND_NONE;
        w.tgt    = STEP_WAIT;
      end
      STEP_DIV_WAIT: begin
        w.cond = COND_DIV_BUSY;
        w.tgt  = STEP_DIV_WAIT;
      end
      STEP_EMIT: begin
        w.out_ld = 1'b1;
        w.cond   = COND_OUT_FULL;
        w.tgt    = STEP_EMIT;
        w.last   = 1'b1;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic thr_t thresholds(cfg_t c);
    thr_t t;
    t = '0;
    case (mode_e'(c.mode))
      MODE_OFFICE: begin
        t.warn = THR_W'(55); t.alrt = THR_W'(65); t.danger = THR_W'(75);
      end
      MODE_HOME: begin
        t.warn = THR_W'(45); t.alrt = THR_W'(55); t.danger = THR_W'(65);
      end
      MODE_SLEEP: begin
        t.warn = THR_W'(35); t.alrt = THR_W'(45); t.danger = THR_W'(55);
      end
      MODE_CUSTOM: begin
        t.warn = c.warn; t.alrt = c.alrt; t.danger = c.danger;
      end
      default: t = '0;
    endcase
    return t;
  endfunction

  // first match from danger down wins, even for unordered thresholds
  function automatic grade_e grade(logic [LEVEL_W-1:0] lvl, thr_t t);
    logic [THR_W-1:0] l;
    l = THR_W'(lvl);
    if (l >= t.danger)    return GRADE_DANGER;
    else if (l >= t.alrt) return GRADE_ALERT;
    else if (l >= t.warn) return GRADE_WARN;
    else                  return GRADE_OK;
  endfunction

endpackage

[design/slws_if.sv]
// sample and result channel interfaces
interface slws_in_if;
  logic                       valid;
  logic                       ready;
  logic [slws_pkg::RAW_W-1:0] raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface slws_out_if;
  logic                         valid;
  logic                         ready;
  logic [slws_pkg::LEVEL_W-1:0] level_db;
  logic [slws_pkg::LEVEL_W-1:0] window_min;
  logic [slws_pkg::LEVEL_W-1:0] window_max;
  logic [slws_pkg::LEVEL_W-1:0] window_avg;
  logic [1:0]                   alert_level;
  modport source (output valid, output level_db, output window_min, output window_max,
                  output window_avg, output alert_level, input ready);
  modport sink   (input valid, input level_db, input window_min, input window_max,
                  input window_avg, input alert_level, output ready);
endinterface

[design/sound_level_window_stats.sv]
// Sound level window statistics. Each 10-bit sample word is mapped to a level of
// 30..100, written into a 100-entry rolling window, and answered by one result word
// with the level, the minimum, maximum and floor average over the filled window, and
// a 0..3 alert grade against the thresholds of the selected mode. After a sample is
// accepted, the window memory is scanned one entry per cycle through its single read
// port over the count filled entries, then a one-bit-per-cycle divider forms the
// average; the sequencer is back in its wait step, ready for the next sample, as the
// result word becomes valid. One word is in work at a time; a finished result waits
// in an output register while the next sample is taken, and the block only stalls
// when that register is still full at the end of the next word. The user must write
// configuration through cfg_we_i / cfg_idx_i / cfg_data_i only while idle; the block
// itself does not enforce this.
module sound_level_window_stats (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [slws_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [slws_pkg::CFG_DATA_W-1:0] cfg_data_i,
  slws_in_if.sink                         sample_i,
  slws_out_if.source                      result_o
);
  import slws_pkg::*;

  cfg_t               cfg_q;
  ctl_t               ctl;
  status_t            status;
  logic               scan_more;
  logic               out_full;
  logic               div_busy;
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   count;
  logic [LEVEL_W-1:0] quotient;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_W'(MODE_OFFICE);
      cfg_q.warn   <= THR_W'(55);
      cfg_q.alrt   <= THR_W'(65);
      cfg_q.danger <= THR_W'(75);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ALERT_MODE:  cfg_q.mode   <= cfg_data_i[MODE_W-1:0];
        CFG_CUSTOM_WARN: cfg_q.warn   <= cfg_data_i[THR_W-1:0];
        CFG_CUSTOM_ALRT: cfg_q.alrt   <= cfg_data_i[THR_W-1:0];
        CFG_CUSTOM_DNGR: cfg_q.danger <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign status.in_valid  = sample_i.valid;
  assign status.scan_more = scan_more;
  assign status.div_busy  = div_busy;
  assign status.out_full  = out_full;

  assign sample_i.ready = ctl.in_rdy;

  slws_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl)
  );

  slws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_go),
    .dividend_i (sum),
    .divisor_i  (count),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  slws_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .cfg_i         (cfg_q),
    .in_valid_i    (sample_i.valid),
    .raw_sample_i  (sample_i.raw_sample),
    .out_ready_i   (result_o.ready),
    .quotient_i    (quotient),
    .scan_more_o   (scan_more),
    .out_full_o    (out_full),
    .sum_o         (sum),
    .count_o       (count),
    .out_valid_o   (result_o.valid),
    .level_db_o    (result_o.level_db),
    .window_min_o  (result_o.window_min),
    .window_max_o  (result_o.window_max),
    .window_avg_o  (result_o.window_avg),
    .alert_level_o (result_o.alert_level)
  );

endmodule

[design/slws_div.sv]
// iterative restoring divider, one quotient bit per cycle
module slws_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [slws_pkg::SUM_W-1:0]   dividend_i,
  input  logic [slws_pkg::CNT_W-1:0]   divisor_i,
  output logic                         busy_o,
  output logic [slws_pkg::LEVEL_W-1:0] quotient_o
);
  import slws_pkg::*;

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              busy_q, busy_d;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              fits;

  always_comb begin
    shifted = {rem_q, quo_q[SUM_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
    rem_d   = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    quo_d   = {quo_q[SUM_W-2:0], fits};
  end

  always_comb begin
    busy_d = busy_q;
    iter_d = iter_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = ITER_W'(SUM_W);
    end else if (busy_q) begin
      iter_d = iter_q - ITER_W'(1);
      if (iter_q == ITER_W'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q[LEVEL_W-1:0];

endmodule

[design/slws_seq.sv]
// microprogram sequencer: step counter, control store and conditional jumps
module slws_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slws_pkg::status_t status_i,
  output slws_pkg::ctl_t    ctl_o
);
  import slws_pkg::*;

  step_e step_q, step_d;
  ctl_t  cw;
  logic  take;

  always_comb begin
    cw = ucode(step_q);
  end

  always_comb begin
    case (cw.cond)
      COND_NONE:      take = 1'b0;
      COND_NO_INPUT:  take = !status_i.in_valid;
      COND_SCAN_MORE: take = status_i.scan_more;
      COND_DIV_BUSY:  take = status_i.div_busy;
      COND_OUT_FULL:  take = status_i.out_full;
      default:        take = 1'b0;
    endcase
  end

  always_comb begin
    if (take)         step_d = cw.tgt;
    else if (cw.last) step_d = STEP_WAIT;
    else              step_d = step_e'(step_q + STEP_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= STEP_WAIT;
    else         step_q <= step_d;
  end

  assign ctl_o = cw;

endmodule

[design/slws_dp.sv]
// datapath: level mapping, window store, scan accumulators and result register
module slws_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slws_pkg::ctl_t               ctl_i,
  input  slws_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  input  logic [slws_pkg::RAW_W-1:0]   raw_sample_i,
  input  logic                         out_ready_i,
  input  logic [slws_pkg::LEVEL_W-1:0] quotient_i,
  output logic                         scan_more_o,
  output logic                         out_full_o,
  output logic [slws_pkg::SUM_W-1:0]   sum_o,
  output logic [slws_pkg::CNT_W-1:0]   count_o,
  output logic                         out_valid_o,
  output logic [slws_pkg::LEVEL_W-1:0] level_db_o,
  output logic [slws_pkg::LEVEL_W-1:0] window_min_o,
  output logic [slws_pkg::LEVEL_W-1:0] window_max_o,
  output logic [slws_pkg::LEVEL_W-1:0] window_avg_o,
  output logic [1:0]                   alert_level_o
);
  import slws_pkg::*;

  logic [LEVEL_W-1:0] mem_q [WINDOW_DEPTH];

  logic               accept;
  logic [RAW_W-1:0]   raw1;
  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   q0;
  logic [RAW_W:0]     rem;
  logic [QUO_W-1:0]   q;
  logic [LEVEL_W-1:0] level;

  logic [PTR_W-1:0]   wptr_q, wptr_d;
  logic               filled_q, filled_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PTR_W-1:0]   idx_q;
  logic               rd_vld_q;
  logic [LEVEL_W-1:0] rdata_q;
  logic [LEVEL_W-1:0] level_q;
  logic [SUM_W-1:0]   sum_q;
  logic [LEVEL_W-1:0] min_q, max_q;

  logic               out_vld_q, out_vld_d;
  logic               out_ld;
  logic [LEVEL_W-1:0] out_level_q, out_min_q, out_max_q, out_avg_q;
  logic [1:0]         out_grade_q;

  assign accept = ctl_i.in_rdy && in_valid_i;

  // divide by 1023 as divide by 1024 plus one correction step
  always_comb begin
    raw1  = (raw_sample_i == '0) ? RAW_W'(1) : raw_sample_i;
    prod  = PROD_W'(raw1) * PROD_W'(LEVEL_SPAN);
    q0    = prod[PROD_W-1:RAW_W];
    rem   = {1'b0, prod[RAW_W-1:0]} + (RAW_W+1)'(q0);
    q     = (rem >= (RAW_W+1)'(RAW_FULL)) ? q0 + QUO_W'(1) : q0;
    level = LEVEL_W'(LEVEL_BASE) + LEVEL_W'(q);
  end

  always_comb begin
    wptr_d   = wptr_q;
    filled_d = filled_q;
    count_d  = count_q;
    if (accept) begin
      if (wptr_q == PTR_W'(WINDOW_DEPTH - 1)) begin
        wptr_d   = '0;
        filled_d = 1'b1;
        count_d  = CNT_W'(WINDOW_DEPTH);
      end else begin
        wptr_d  = wptr_q + PTR_W'(1);
        count_d = filled_q ? CNT_W'(WINDOW_DEPTH) : CNT_W'(wptr_q) + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q    <= '0;
      filled_q  <= 1'b0;
      count_q   <= CNT_W'(1);
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      wptr_q    <= wptr_d;
      filled_q  <= filled_d;
      count_q   <= count_d;
      rd_vld_q  <= ctl_i.rd;
      out_vld_q <= out_vld_d;
      if (accept)        idx_q <= '0;
      else if (ctl_i.rd) idx_q <= idx_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) mem_q[wptr_q] <= level;
    if (ctl_i.rd) rdata_q <= mem_q[idx_q];
  end

  // read data is registered and lands in the cycle after its address, so the sums trail the scan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_q <= level;
      sum_q   <= '0;
      min_q   <= '1;
      max_q   <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + SUM_W'(rdata_q);
      if (rdata_q < min_q) min_q <= rdata_q;
      if (rdata_q > max_q) max_q <= rdata_q;
    end
  end

  assign scan_more_o = (CNT_W'(idx_q) + CNT_W'(1)) != count_q;

  // result register frees the sequencer while the word waits
  assign out_full_o = out_vld_q && !out_ready_i;
  assign out_ld     = ctl_i.out_ld && !out_full_o;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ld)           out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_level_q <= level_q;
      out_min_q   <= min_q;
      out_max_q   <= max_q;
      out_avg_q   <= quotient_i;
      out_grade_q <= grade(level_q, thresholds(cfg_i));
    end
  end

  assign sum_o         = sum_q;
  assign count_o       = count_q;
  assign out_valid_o   = out_vld_q;
  assign level_db_o    = out_level_q;
  assign window_min_o  = out_min_q;
  assign window_max_o  = out_max_q;
  assign window_avg_o  = out_avg_q;
  assign alert_level_o = out_grade_q;

endmodule
